// File: src/serc_pkg.sv
package serc_pkg;

    localparam int COORD_BITS   = 32;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int QCAP_BIT     = 62;
    localparam int SUM_BITS     = QCAP_BIT + 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_BITS     = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_LOW  = 2'd0,
        CFG_X_HIGH = 2'd1,
        CFG_Y_LOW  = 2'd2,
        CFG_Y_HIGH = 2'd3
    } cfg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;

    typedef struct packed {
        coord_t x_low;
        coord_t x_high;
        coord_t y_low;
        coord_t y_high;
    } cfg_t;

    typedef struct packed {
        coord_t ix;
        coord_t iy;
        coord_t cx;
        coord_t cy;
        logic   degen;
    } item_t;

    typedef struct packed {
        logic   act;
        coord_t base;
        diff_t  n1;
        diff_t  n2;
        diff_t  den;
    } op_t;

    typedef struct packed {
        op_t   op;
        item_t item;
    } entry_t;

    function automatic diff_t diff(input coord_t a, input coord_t b);
        return diff_t'({a[COORD_BITS-1], a}) - diff_t'({b[COORD_BITS-1], b});
    endfunction

endpackage

// File: src/serc_front.sv
module serc_front (
    input  serc_pkg::cfg_t   cfg,
    input  serc_pkg::coord_t inside_x,
    input  serc_pkg::coord_t inside_y,
    input  serc_pkg::coord_t outside_x,
    input  serc_pkg::coord_t outside_y,
    output serc_pkg::entry_t entry
);
    import serc_pkg::*;

    logic   clip;
    coord_t bound;
    diff_t  den;

    always_comb
    begin
        clip  = 1'b1;
        bound = cfg.x_low;
        priority if (outside_x < cfg.x_low)
            bound = cfg.x_low;
        else if (outside_x > cfg.x_high)
            bound = cfg.x_high;
        else
            clip = 1'b0;
        den = diff(outside_x, inside_x);

        entry.op.act     = clip && (den != '0);
        entry.op.base    = inside_y;
        entry.op.n1      = diff(outside_y, inside_y);
        entry.op.n2      = diff(bound, inside_x);
        entry.op.den     = den;
        entry.item.ix    = inside_x;
        entry.item.iy    = inside_y;
        entry.item.cx    = clip ? bound : outside_x;
        entry.item.cy    = outside_y;
        entry.item.degen = clip && (den == '0);
    end

endmodule

// File: src/serc_fifo.sv
module serc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  serc_pkg::entry_t wr_data,
    input  logic             rd,
    output serc_pkg::entry_t rd_data,
    output logic             full,
    output logic             empty
);
    import serc_pkg::*;

    entry_t              mem [FIFO_DEPTH];
    logic [PTR_BITS:0]   wr_ptr_reg, rd_ptr_reg;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[PTR_BITS] != rd_ptr_reg[PTR_BITS]) &&
                     (wr_ptr_reg[PTR_BITS-1:0] == rd_ptr_reg[PTR_BITS-1:0]);
    assign rd_data = mem[rd_ptr_reg[PTR_BITS-1:0]];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem[wr_ptr_reg[PTR_BITS-1:0]] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

// File: src/serc_clip.sv
module serc_clip (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  serc_pkg::op_t    in_op,
    input  serc_pkg::item_t  in_item,
    output logic             out_valid,
    output logic             out_act,
    output serc_pkg::coord_t out_result,
    output serc_pkg::item_t  out_item
);
    import serc_pkg::*;

    localparam int NS = PROD_BITS + 1;

    logic [PROD_BITS-1:0] w_reg    [NS];
    logic [DIFF_BITS-1:0] r_reg    [NS];
    logic [DIFF_BITS-1:0] d_reg    [NS];
    logic                 neg_reg  [NS];
    logic                 act_reg  [NS];
    coord_t               base_reg [NS];
    item_t                item_reg [NS];
    logic                 vld_reg  [NS];

    coord_t res_reg;
    item_t  oitem_reg;
    logic   oact_reg;
    logic   ovld_reg;

    function automatic logic [DIFF_BITS-1:0] mag(input diff_t v);
        return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
    endfunction

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0]    <= PROD_BITS'(mag(in_op.n1)) * PROD_BITS'(mag(in_op.n2));
            r_reg[0]    <= '0;
            d_reg[0]    <= mag(in_op.den);
            neg_reg[0]  <= in_op.n1[DIFF_BITS-1] ^ in_op.n2[DIFF_BITS-1] ^
                           in_op.den[DIFF_BITS-1];
            act_reg[0]  <= in_op.act;
            base_reg[0] <= in_op.base;
            item_reg[0] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < PROD_BITS; k++)
    begin : g_div
        logic [DIFF_BITS:0]   t;
        logic                 ge;
        logic [DIFF_BITS:0]   sub;

        assign t   = {r_reg[k], w_reg[k][PROD_BITS-1]};
        assign ge  = (t >= {1'b0, d_reg[k]});
        assign sub = t - {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]    <= ge ? sub[DIFF_BITS-1:0] : t[DIFF_BITS-1:0];
                w_reg[k+1]    <= {w_reg[k][PROD_BITS-2:0], ge};
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                act_reg[k+1]  <= act_reg[k];
                base_reg[k+1] <= base_reg[k];
                item_reg[k+1] <= item_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    logic [PROD_BITS-1:0]       q;
    logic [QCAP_BIT:0]          qc;
    logic signed [SUM_BITS-1:0] qs;
    logic signed [SUM_BITS-1:0] sum;
    coord_t                     sat;

    localparam logic signed [SUM_BITS-1:0] CMAX =
        SUM_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [SUM_BITS-1:0] CMIN = -CMAX - 1;

    // cap, apply sign, add and saturate
    always_comb
    begin
        q   = w_reg[NS-1];
        qc  = (|q[PROD_BITS-1:QCAP_BIT]) ? {1'b1, {QCAP_BIT{1'b0}}}
                                         : q[QCAP_BIT:0];
        qs  = neg_reg[NS-1] ? -SUM_BITS'(qc) : SUM_BITS'(qc);
        sum = SUM_BITS'(base_reg[NS-1]) + qs;
        priority if (sum > CMAX)
            sat = coord_t'(CMAX[COORD_BITS-1:0]);
        else if (sum < CMIN)
            sat = coord_t'(CMIN[COORD_BITS-1:0]);
        else
            sat = sum[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= sat;
            oitem_reg <= item_reg[NS-1];
            oact_reg  <= act_reg[NS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (en)
            ovld_reg <= vld_reg[NS-1];
    end

    assign out_valid  = ovld_reg;
    assign out_act    = oact_reg;
    assign out_result = res_reg;
    assign out_item   = oitem_reg;

endmodule

// File: src/serc_back.sv
module serc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  serc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  serc_pkg::entry_t in_entry,
    output logic             in_take,
    output logic             out_valid,
    input  logic             out_stall,
    output serc_pkg::coord_t clip_x,
    output serc_pkg::coord_t clip_y,
    output logic             degenerate
);
    import serc_pkg::*;

    logic   adv;
    logic   x_valid, y_valid;
    logic   x_act, y_act;
    coord_t x_res, y_res;
    item_t  x_item, y_item, x_fix, y_in, fin_item;
    op_t    mid_op;
    logic   clip;
    coord_t bound;
    diff_t  den;
    logic   ovld_reg;
    item_t  out_reg;

    // whole pipeline holds while the output register is full and stalled
    assign adv     = !ovld_reg || !out_stall;
    assign in_take = adv && in_valid;

    serc_clip u_clip_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_op     (in_entry.op),
        .in_item   (in_entry.item),
        .out_valid (x_valid),
        .out_act   (x_act),
        .out_result(x_res),
        .out_item  (x_item)
    );

    // x clip result replaces cy only when that clip ran
    always_comb
    begin
        x_fix = x_item;
        if (x_act)
            x_fix.cy = x_res;
    end

    always_comb
    begin
        clip  = 1'b1;
        bound = cfg.y_low;
        priority if (x_fix.cy < cfg.y_low)
            bound = cfg.y_low;
        else if (x_fix.cy > cfg.y_high)
            bound = cfg.y_high;
        else
            clip = 1'b0;
        den = diff(x_fix.cy, x_fix.iy);

        mid_op.act  = clip && (den != '0);
        mid_op.base = x_fix.ix;
        mid_op.n1   = diff(x_fix.cx, x_fix.ix);
        mid_op.n2   = diff(bound, x_fix.iy);
        mid_op.den  = den;
    end

    always_comb
    begin
        y_in       = x_fix;
        y_in.cy    = clip ? bound : x_fix.cy;
        y_in.degen = x_fix.degen || (clip && (den == '0));
    end

    serc_clip u_clip_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (x_valid),
        .in_op     (mid_op),
        .in_item   (y_in),
        .out_valid (y_valid),
        .out_act   (y_act),
        .out_result(y_res),
        .out_item  (y_item)
    );

    always_comb
    begin
        fin_item = y_item;
        if (y_act)
            fin_item.cx = y_res;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= fin_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (adv)
            ovld_reg <= y_valid;
    end

    assign out_valid  = ovld_reg;
    assign clip_x     = out_reg.cx;
    assign clip_y     = out_reg.cy;
    assign degenerate = out_reg.degen;

endmodule

// File: src/segment_endpoint_rect_clip.sv
// Segment endpoint clipping against a configured rectangle.
//
// Input channel (in_valid / in_stall) carries an inside point and a point
// that may lie outside the rectangle, all Q16.16 signed. The output channel
// (out_valid / out_stall) returns the point where the segment leaves the
// rectangle, x clip first and then y clip, with a degenerate flag when a
// needed denominator was zero.
//
// One transaction is accepted every cycle while the queue is not full. A result
// passes through the front queue, then two clip units (multiply, one quotient
// bit per stage over the 66-bit product, then add and saturate), then the
// output register.
//
// When the receiver stalls, the output register and both clip pipelines
// hold; the front keeps taking transactions until its four-entry queue is
// full, then raises in_stall. Reset empties the queue and pipelines and
// sets the rectangle to x 0..1.0, y 0..1.0. Write bounds only while idle.
module segment_endpoint_rect_clip (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [serc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [serc_pkg::COORD_BITS-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [serc_pkg::COORD_BITS-1:0] inside_x,
    input  logic signed [serc_pkg::COORD_BITS-1:0] inside_y,
    input  logic signed [serc_pkg::COORD_BITS-1:0] outside_x,
    input  logic signed [serc_pkg::COORD_BITS-1:0] outside_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [serc_pkg::COORD_BITS-1:0] clip_x,
    output logic signed [serc_pkg::COORD_BITS-1:0] clip_y,
    output logic                                degenerate
);
    import serc_pkg::*;

    cfg_t   cfg_reg;
    entry_t f_entry, q_entry;
    logic   q_full, q_empty, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_low  <= coord_t'(0);
            cfg_reg.x_high <= coord_t'(65536);
            cfg_reg.y_low  <= coord_t'(0);
            cfg_reg.y_high <= coord_t'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_X_LOW:  cfg_reg.x_low  <= cfg_data;
                CFG_X_HIGH: cfg_reg.x_high <= cfg_data;
                CFG_Y_LOW:  cfg_reg.y_low  <= cfg_data;
                CFG_Y_HIGH: cfg_reg.y_high <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    serc_front u_front (
        .cfg      (cfg_reg),
        .inside_x (inside_x),
        .inside_y (inside_y),
        .outside_x(outside_x),
        .outside_y(outside_y),
        .entry    (f_entry)
    );

    assign in_stall = q_full;

    serc_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (in_valid),
        .wr_data(f_entry),
        .rd     (q_take),
        .rd_data(q_entry),
        .full   (q_full),
        .empty  (q_empty)
    );

    serc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (!q_empty),
        .in_entry  (q_entry),
        .in_take   (q_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .degenerate(degenerate)
    );

endmodule

// File: sim/tb_segment_endpoint_rect_clip.sv
`timescale 1ns / 100ps

module tb_segment_endpoint_rect_clip;
    import serc_pkg::*;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint QLIM = 64'sd1 <<< 62;

    typedef struct {
        longint x;
        longint y;
        bit     degen;
    } endpoint_t;

    typedef struct {
        longint ix;
        longint iy;
        longint ox;
        longint oy;
        bit     typed;
        longint ex;
        longint ey;
        bit     ed;
    } row_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_X_LOW;
    logic [COORD_BITS-1:0]   cfg_data = '0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t inside_x = '0;
    coord_t inside_y = '0;
    coord_t outside_x = '0;
    coord_t outside_y = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    coord_t clip_x;
    coord_t clip_y;
    logic   degenerate;

    longint    rect_xl, rect_xh, rect_yl, rect_yh;
    endpoint_t pending_clips[$];
    int        mismatches = 0;
    int        clips_seen = 0;
    int        degen_seen = 0;
    int        items_sent = 0;
    bit        quiet = 1'b0;

    segment_endpoint_rect_clip u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .inside_x   (inside_x),
        .inside_y   (inside_y),
        .outside_x  (outside_x),
        .outside_y  (outside_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .clip_x     (clip_x),
        .clip_y     (clip_y),
        .degenerate (degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("[segment_endpoint_rect_clip] ERROR");
        $finish;
    end

    // base + n1 * n2 / den, exact product, quotient toward zero, capped then saturated
    function automatic longint lerp_sat(longint base, longint n1, longint n2, longint den);
        logic signed [127:0] a, b, d, q;
        longint r;
        a = n1;
        b = n2;
        d = den;
        q = (a * b) / d;
        if (q > QLIM)
            q = QLIM;
        if (q < -QLIM)
            q = -QLIM;
        r = base + longint'(q[63:0]);
        if (r > CMAX)
            r = CMAX;
        if (r < CMIN)
            r = CMIN;
        return r;
    endfunction

    function automatic endpoint_t clip_endpoint(longint ix, longint iy, longint ox, longint oy);
        endpoint_t e;
        longint bnd;
        bit hit;
        e.x = ox;
        e.y = oy;
        e.degen = 1'b0;
        hit = 1'b1;
        if (e.x < rect_xl)
            bnd = rect_xl;
        else if (e.x > rect_xh)
            bnd = rect_xh;
        else
            hit = 1'b0;
        if (hit)
        begin
            if (e.x == ix)
                e.degen = 1'b1;
            else
                e.y = lerp_sat(iy, e.y - iy, bnd - ix, e.x - ix);
            e.x = bnd;
        end
        hit = 1'b1;
        if (e.y < rect_yl)
            bnd = rect_yl;
        else if (e.y > rect_yh)
            bnd = rect_yh;
        else
            hit = 1'b0;
        if (hit)
        begin
            if (e.y == iy)
                e.degen = 1'b1;
            else
                e.x = lerp_sat(ix, e.x - ix, bnd - iy, e.y - iy);
            e.y = bnd;
        end
        return e;
    endfunction

    function automatic longint rand_in(longint lo, longint hi);
        bit [63:0] span;
        longint v;
        span = hi - lo + 1;
        v = lo + longint'({$urandom, $urandom} % span);
        if (v > CMAX)
            v = CMAX;
        if (v < CMIN)
            v = CMIN;
        return v;
    endfunction

    function automatic longint rand_word();
        return longint'(coord_t'($urandom));
    endfunction

    task automatic write_bounds(longint xl, longint xh, longint yl, longint yh);
        longint vals[4];
        vals = '{xl, xh, yl, yh};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_BITS-1:0];
            cfg_data  <= vals[i][COORD_BITS-1:0];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        rect_xl = xl;
        rect_xh = xh;
        rect_yl = yl;
        rect_yh = yh;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_clips.size() > 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic send_segment(row_t r);
        endpoint_t e;
        while (!quiet && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        inside_x  <= r.ix[COORD_BITS-1:0];
        inside_y  <= r.iy[COORD_BITS-1:0];
        outside_x <= r.ox[COORD_BITS-1:0];
        outside_y <= r.oy[COORD_BITS-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = clip_endpoint(r.ix, r.iy, r.ox, r.oy);
        if (r.typed)
        begin
            if (e.x != r.ex || e.y != r.ey || e.degen != r.ed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with predictor: %0d %0d %0d vs %0d %0d %0d",
                             r.ex, r.ey, r.ed, e.x, e.y, e.degen);
            end
            e.x = r.ex;
            e.y = r.ey;
            e.degen = r.ed;
        end
        pending_clips.push_back(e);
        items_sent++;
    endtask

    task automatic random_segments(int count);
        row_t r;
        longint xl, xh, yl, yh;
        for (int n = 0; n < count; n++)
        begin
            xl = rect_xl < rect_xh ? rect_xl : rect_xh;
            xh = rect_xl < rect_xh ? rect_xh : rect_xl;
            yl = rect_yl < rect_yh ? rect_yl : rect_yh;
            yh = rect_yl < rect_yh ? rect_yh : rect_yl;
            r.typed = 1'b0;
            if ($urandom_range(99) < 75)
            begin
                r.ix = rand_in(xl, xh);
                r.iy = rand_in(yl, yh);
                r.ox = rand_in(xl - (xh - xl) - 2, xh + (xh - xl) + 2);
                r.oy = rand_in(yl - (yh - yl) - 2, yh + (yh - yl) + 2);
                // force axis-parallel segments now and then
                if ($urandom_range(15) == 0)
                    r.ox = r.ix;
                if ($urandom_range(15) == 0)
                    r.oy = r.iy;
            end
            else
            begin
                r.ix = rand_word();
                r.iy = rand_word();
                r.ox = rand_word();
                r.oy = rand_word();
            end
            if (n == count / 2)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            send_segment(r);
        end
    endtask

    // output side: check and randomize stall
    always @(posedge clk)
    begin
        endpoint_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_clips.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d %0d %0d", clip_x, clip_y, degenerate);
                end
                else
                begin
                    e = pending_clips.pop_front();
                    clips_seen++;
                    if (e.degen)
                        degen_seen++;
                    if (longint'(clip_x) != e.x || longint'(clip_y) != e.y
                        || degenerate != e.degen)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     e.x, e.y, e.degen, clip_x, clip_y, degenerate);
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 28);
        end
    end

    initial
    begin
        row_t dir[$];
        rect_xl = 0;
        rect_xh = 65536;
        rect_yl = 0;
        rect_yh = 65536;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rectangle 0..1.0 on both axes
        dir.push_back('{32768, 32768, 40000, 50000, 1, 40000, 50000, 0});
        dir.push_back('{0, 0, 131072, 131072, 1, 65536, 65536, 0});
        dir.push_back('{0, 0, -131072, 65536, 1, 0, 0, 0});
        dir.push_back('{-5, 100, -5, 200, 1, 0, 200, 1});
        dir.push_back('{100, 32768, 200, 32768 + 65536, 1, 150, 65536, 0});
        dir.push_back('{5, 100, 7, 100, 1, 7, 100, 0});
        dir.push_back('{300, 300, 300, -900, 1, 300, 0, 0});
        dir.push_back('{0, 0, CMIN, CMAX, 0, 0, 0, 0});
        dir.push_back('{CMAX, CMIN, CMIN, CMAX, 0, 0, 0, 0});
        dir.push_back('{CMIN, CMAX, CMAX, CMIN, 0, 0, 0, 0});
        dir.push_back('{-1, -1, CMAX, CMAX, 0, 0, 0, 0});
        dir.push_back('{65536, 65536, 65536, 65536, 1, 65536, 65536, 0});
        foreach (dir[i])
            send_segment(dir[i]);
        in_valid <= 1'b0;
        wait_drained();

        // widest rectangle: nothing clips
        write_bounds(CMIN, CMAX, CMIN, CMAX);
        send_segment('{0, 0, CMIN, CMAX, 1, CMIN, CMAX, 0});
        send_segment('{CMAX, CMIN, CMAX, CMIN, 1, CMAX, CMIN, 0});
        random_segments(150);
        in_valid <= 1'b0;
        wait_drained();

        // inverted bounds: low test wins
        write_bounds(65536, -65536, 131072, -131072);
        send_segment('{0, 0, -100000, 0, 0, 0, 0, 0});
        send_segment('{CMAX, CMAX, CMIN, CMIN, 0, 0, 0, 0});
        random_segments(150);
        in_valid <= 1'b0;
        wait_drained();

        write_bounds(-(1 << 20), 1 << 20, -(1 << 18), 1 << 22);
        quiet = 1'b1;
        random_segments(200);
        quiet = 1'b0;
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            longint a, b, c, d;
            a = rand_word();
            b = rand_word();
            c = rand_word();
            d = rand_word();
            write_bounds(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
            random_segments(150);
            in_valid <= 1'b0;
            wait_drained();
        end

        write_bounds(0, 65536, 0, 65536);
        random_segments(20);
        in_valid <= 1'b0;
        wait_drained();

        $display("segments sent %0d, results checked %0d, degenerate %0d",
                 items_sent, clips_seen, degen_seen);
        $display("rectangles covered: reset, full range, inverted, fixed and random bounds");
        if (mismatches == 0 && pending_clips.size() == 0)
            $display("[segment_endpoint_rect_clip] OK");
        else
            $display("[segment_endpoint_rect_clip] ERROR");
        $finish;
    end

endmodule
